// File: hw/rtl/aup_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// aup_pkg - shared types for the alpha unpremultiply pipeline
// The word that travels down the divider chain, and its fixed sizes.
// ---------------------------------------------------------------------------
package aup_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned NUM_BYTES = 4;
	localparam int unsigned NUM_LANES = 3;
	// one quotient bit per cell
	localparam int unsigned DIV_STEPS = 8;
	localparam logic [BYTE_W-1:0] FULL_SCALE = 8'hFF;

	localparam logic ORDER_RGBA = 1'b0;
	localparam logic ORDER_ARGB = 1'b1;

	typedef logic [BYTE_W-1:0] byte_t;

	typedef struct packed {
		byte_t [NUM_BYTES-1:0] px;     // pixel as received
		logic                  order;  // channel order in force for this pixel
		logic                  bypass; // alpha is zero
		byte_t                 alpha;
		logic  [NUM_LANES-1:0] sat;    // colour above alpha
		byte_t [NUM_LANES-1:0] rem;    // partial remainder
		byte_t [NUM_LANES-1:0] lo;     // dividend bits still to shift in
		byte_t [NUM_LANES-1:0] quo;    // quotient bits so far
	} word_t;

endpackage
`default_nettype wire

// File: hw/rtl/aup_prep.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// aup_prep - front stage of the unpremultiply chain
// Picks alpha and colour bytes by channel order, scales colour by 255 and
// loads the divider word.
// ---------------------------------------------------------------------------
module aup_prep (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     order,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire aup_pkg::byte_t [3:0]     in_px,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output aup_pkg::word_t                out_word
);

	logic           valid_q;
	aup_pkg::word_t word_q;
	aup_pkg::word_t word_d;
	aup_pkg::byte_t [aup_pkg::NUM_LANES-1:0] colour;
	logic [2*aup_pkg::BYTE_W-1:0] scaled [aup_pkg::NUM_LANES];

	always_comb begin
		word_d        = '0;
		word_d.px     = in_px;
		word_d.order  = order;
		word_d.alpha  = (order == aup_pkg::ORDER_ARGB) ? in_px[0] : in_px[3];
		word_d.bypass = (word_d.alpha == '0);
		for (int k = 0; k < aup_pkg::NUM_LANES; k++) begin
			colour[k] = (order == aup_pkg::ORDER_ARGB) ? in_px[k+1] : in_px[k];
			// c * 255 as (c << 8) - c
			scaled[k] = {colour[k], 8'h00} - {8'h00, colour[k]};
			// quotient exceeds 255 exactly when colour exceeds alpha
			word_d.sat[k] = (colour[k] > word_d.alpha);
			word_d.rem[k] = scaled[k][15:8];
			word_d.lo[k]  = scaled[k][7:0];
		end
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_word  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_q <= word_d;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/aup_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// aup_cell - one restoring division step
// Shifts one dividend bit into each lane's remainder and settles one
// quotient bit against alpha.
// ---------------------------------------------------------------------------
module aup_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire aup_pkg::word_t in_word,
	output logic                out_valid,
	input  wire logic           out_ready,
	output aup_pkg::word_t      out_word
);

	logic           valid_q;
	aup_pkg::word_t word_q;
	aup_pkg::word_t word_d;
	logic [aup_pkg::BYTE_W:0] trial [aup_pkg::NUM_LANES];
	logic [aup_pkg::BYTE_W:0] diff  [aup_pkg::NUM_LANES];
	logic [aup_pkg::NUM_LANES-1:0] take;

	always_comb begin
		word_d = in_word;
		for (int k = 0; k < aup_pkg::NUM_LANES; k++) begin
			trial[k] = {in_word.rem[k], in_word.lo[k][aup_pkg::BYTE_W-1]};
			diff[k]  = trial[k] - {1'b0, in_word.alpha};
			take[k]  = (trial[k] >= {1'b0, in_word.alpha});
			word_d.rem[k] = take[k] ? diff[k][aup_pkg::BYTE_W-1:0]
			                        : trial[k][aup_pkg::BYTE_W-1:0];
			word_d.lo[k]  = {in_word.lo[k][aup_pkg::BYTE_W-2:0], 1'b0};
			word_d.quo[k] = {in_word.quo[k][aup_pkg::BYTE_W-2:0], take[k]};
		end
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_word  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_q <= word_d;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/alpha_unpremultiply.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// alpha_unpremultiply - undo premultiplied alpha on RGBA8888 pixels
// Input words carry one pixel on s_axis_tdata, memory byte 0 in bits 7:0.
// Output words carry the pixel with each colour byte replaced by
// floor(colour * 255 / alpha), alpha kept; m_axis_tuser flags a pixel where
// colour exceeded alpha and the result was clamped to 255. Zero alpha
// passes the pixel through unchanged.
// cfg_wr_en/cfg_wr_data set the channel order (0 RGBA, 1 ARGB); write it
// only while the pipeline is empty.
// The pipeline is one scaling stage, a chain of eight division
// cells giving one quotient bit each, and the output register.
// Throughput is one pixel per clock while the receiver takes words; each stage holds its own word and
// takes a new one whenever it is empty or its successor takes its word,
// so a stalled receiver only backs the chain up until bubbles are filled.
// Reset empties every stage and sets the order to RGBA.
// ---------------------------------------------------------------------------
module alpha_unpremultiply (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_wr_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // byte_zero, byte_one, byte_two, byte_three
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // out_byte_zero .. out_byte_three
	output logic             m_axis_tuser   // saturated
);

	logic order_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= aup_pkg::ORDER_RGBA;
		end else if (cfg_wr_en) begin
			order_q <= cfg_wr_data;
		end
	end

	aup_pkg::word_t word   [aup_pkg::DIV_STEPS+1];
	logic           valid  [aup_pkg::DIV_STEPS+1];
	logic           ready  [aup_pkg::DIV_STEPS+1];

	aup_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.order     (order_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_px     (s_axis_tdata),
		.out_valid (valid[0]),
		.out_ready (ready[0]),
		.out_word  (word[0])
	);

	for (genvar g = 0; g < aup_pkg::DIV_STEPS; g++) begin : g_cell
		aup_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid[g]),
			.in_ready  (ready[g]),
			.in_word   (word[g]),
			.out_valid (valid[g+1]),
			.out_ready (ready[g+1]),
			.out_word  (word[g+1])
		);
	end

	// output stage: put the quotients back in place
	aup_pkg::word_t                           last;
	aup_pkg::byte_t [aup_pkg::NUM_BYTES-1:0]  res;
	aup_pkg::byte_t                           val;
	logic                                     out_valid_q;
	logic                                     out_ready;
	logic [31:0]                              out_data_q;
	logic                                     out_sat_q;

	assign last = word[aup_pkg::DIV_STEPS];

	always_comb begin
		res = last.px;
		val = '0;
		for (int k = 0; k < aup_pkg::NUM_LANES; k++) begin
			if (last.bypass) begin
				val = (last.order == aup_pkg::ORDER_ARGB) ? last.px[k+1] : last.px[k];
			end else if (last.sat[k]) begin
				val = aup_pkg::FULL_SCALE;
			end else begin
				val = last.quo[k];
			end
			if (last.order == aup_pkg::ORDER_ARGB) begin
				res[k+1] = val;
			end else begin
				res[k] = val;
			end
		end
	end

	assign out_ready                = !out_valid_q || m_axis_tready;
	assign ready[aup_pkg::DIV_STEPS] = out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid[aup_pkg::DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && valid[aup_pkg::DIV_STEPS]) begin
			out_data_q <= res;
			out_sat_q  <= !last.bypass && (|last.sat);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_sat_q;

endmodule
`default_nettype wire

// File: hw/rtl/aup_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// aup_checker - port-level checks for alpha_unpremultiply
// Watches the stream ports over time; attached to the top level by bind.
// ---------------------------------------------------------------------------
module aup_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata,
	input wire logic        m_axis_tuser
);

	// hold a stalled word
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled output word changed");

	// a free receiver leaves no stage blocked
	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while receiver ready");

	// a clamped pixel carries at least one full-scale byte
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			(m_axis_tdata[7:0] == 8'hFF) || (m_axis_tdata[15:8] == 8'hFF) ||
			(m_axis_tdata[23:16] == 8'hFF) || (m_axis_tdata[31:24] == 8'hFF))
		else $error("saturated flag without a clamped byte");

	// a clamped pixel never has zero alpha in both candidate positions
	a_sat_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			(m_axis_tdata[7:0] != 8'h00) || (m_axis_tdata[31:24] != 8'h00))
		else $error("saturated flag on a zero-alpha pixel");

endmodule

bind alpha_unpremultiply aup_checker u_aup_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// File: dv/tb_alpha_unpremultiply.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_alpha_unpremultiply - self-checking bench for the unpremultiply pipeline
// A directed table covers zero alpha, full and unit alpha, colour above
// alpha and both channel orders. Random pixels follow in phases that switch
// the channel order and the idling of sender and receiver. Every output word
// is checked byte by byte, saturation flag included, against a local
// predictor or against the value typed into the table.
// ---------------------------------------------------------------------------
module tb_alpha_unpremultiply;

	localparam int unsigned PIPE_LATENCY = 10;
	localparam int unsigned PHASE_PIXELS = 200;
	localparam int unsigned NUM_PHASES   = 8;
	localparam int unsigned NUM_ROWS     = 18;
	localparam int unsigned REPORT_MAX   = 10;

	typedef struct packed {
		logic [31:0] px;
		logic        sat;
	} result_t;

	typedef struct packed {
		logic        order;
		logic [31:0] px;
		logic        typed;   // expectation given below, else predicted
		logic [31:0] want_px;
		logic        want_sat;
	} row_t;

	typedef struct packed {
		logic       order;
		logic [6:0] src_idle;
		logic [6:0] sink_stall;
	} phase_t;

	localparam row_t DIRECTED [NUM_ROWS] = '{
		'{aup_pkg::ORDER_RGBA, 32'h00_01_80_FF, 1'b1, 32'h00_01_80_FF, 1'b0},
		'{aup_pkg::ORDER_RGBA, 32'hFF_FF_7F_00, 1'b1, 32'hFF_FF_7F_00, 1'b0},
		'{aup_pkg::ORDER_RGBA, 32'h01_00_01_00, 1'b1, 32'h01_00_FF_00, 1'b0},
		'{aup_pkg::ORDER_RGBA, 32'h01_FF_00_02, 1'b1, 32'h01_FF_00_FF, 1'b1},
		'{aup_pkg::ORDER_RGBA, 32'h80_00_40_80, 1'b0, 32'h0,           1'b0},
		'{aup_pkg::ORDER_RGBA, 32'hFF_FF_FF_FF, 1'b1, 32'hFF_FF_FF_FF, 1'b0},
		'{aup_pkg::ORDER_RGBA, 32'h00_00_00_00, 1'b1, 32'h00_00_00_00, 1'b0},
		'{aup_pkg::ORDER_RGBA, 32'h10_0F_10_11, 1'b0, 32'h0,           1'b0},
		'{aup_pkg::ORDER_RGBA, 32'h00_FF_FF_FF, 1'b1, 32'h00_FF_FF_FF, 1'b0},
		'{aup_pkg::ORDER_ARGB, 32'h01_80_FF_00, 1'b1, 32'h01_80_FF_00, 1'b0},
		'{aup_pkg::ORDER_ARGB, 32'h00_7F_FF_FF, 1'b1, 32'h00_7F_FF_FF, 1'b0},
		'{aup_pkg::ORDER_ARGB, 32'h00_02_01_01, 1'b1, 32'h00_FF_FF_01, 1'b1},
		'{aup_pkg::ORDER_ARGB, 32'hFF_20_40_40, 1'b0, 32'h0,           1'b0},
		'{aup_pkg::ORDER_ARGB, 32'hFF_FF_FF_FF, 1'b1, 32'hFF_FF_FF_FF, 1'b0},
		'{aup_pkg::ORDER_ARGB, 32'h00_00_00_00, 1'b1, 32'h00_00_00_00, 1'b0},
		'{aup_pkg::ORDER_ARGB, 32'h10_80_01_C0, 1'b0, 32'h0,           1'b0},
		'{aup_pkg::ORDER_RGBA, 32'h00_10_20_FF, 1'b1, 32'h00_10_20_FF, 1'b0},
		'{aup_pkg::ORDER_RGBA, 32'hC0_BF_01_7F, 1'b0, 32'h0,           1'b0}
	};

	localparam phase_t PHASES [NUM_PHASES] = '{
		'{aup_pkg::ORDER_ARGB, 7'd0,  7'd0},
		'{aup_pkg::ORDER_RGBA, 7'd49, 7'd0},
		'{aup_pkg::ORDER_ARGB, 7'd0,  7'd49},
		'{aup_pkg::ORDER_RGBA, 7'd14, 7'd14},
		'{aup_pkg::ORDER_RGBA, 7'd0,  7'd0},
		'{aup_pkg::ORDER_ARGB, 7'd49, 7'd0},
		'{aup_pkg::ORDER_RGBA, 7'd0,  7'd49},
		'{aup_pkg::ORDER_ARGB, 7'd14, 7'd14}
	};

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_wr_en     = 1'b0;
	logic        cfg_wr_data   = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tuser;

	logic        channel_order  = aup_pkg::ORDER_RGBA;
	int unsigned src_idle_pct   = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned fault_count    = 0;
	result_t     pending_pixels [$];

	alpha_unpremultiply i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic result_t unpremultiply(input logic order, input logic [31:0] px);
		aup_pkg::byte_t b [aup_pkg::NUM_BYTES];
		aup_pkg::byte_t alpha;
		int unsigned    first;
		int unsigned    quo;
		result_t        res;
		for (int i = 0; i < aup_pkg::NUM_BYTES; i++)
			b[i] = px[i*aup_pkg::BYTE_W +: aup_pkg::BYTE_W];
		alpha = (order == aup_pkg::ORDER_ARGB) ? b[0] : b[aup_pkg::NUM_BYTES-1];
		first = (order == aup_pkg::ORDER_ARGB) ? 1 : 0;
		res.sat = 1'b0;
		if (alpha != 0) begin
			for (int k = first; k < first + aup_pkg::NUM_LANES; k++) begin
				quo = (int'(b[k]) * int'(aup_pkg::FULL_SCALE)) / int'(alpha);
				if (quo > int'(aup_pkg::FULL_SCALE)) begin
					quo     = aup_pkg::FULL_SCALE;
					res.sat = 1'b1;
				end
				b[k] = aup_pkg::byte_t'(quo);
			end
		end
		for (int i = 0; i < aup_pkg::NUM_BYTES; i++)
			res.px[i*aup_pkg::BYTE_W +: aup_pkg::BYTE_W] = b[i];
		return res;
	endfunction

	// mostly well-formed premultiplied pixels, with zero alpha, extreme alpha
	// and colour above alpha mixed in
	function automatic logic [31:0] random_pixel(input logic order);
		aup_pkg::byte_t alpha;
		aup_pkg::byte_t col [aup_pkg::NUM_LANES];
		int unsigned    kind;
		kind = $urandom_range(0, 9);
		case (kind)
			0: alpha = 8'h00;
			1: alpha = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h01;
			default: alpha = aup_pkg::byte_t'($urandom_range(1, 255));
		endcase
		for (int k = 0; k < aup_pkg::NUM_LANES; k++) begin
			if (kind <= 2)
				col[k] = aup_pkg::byte_t'($urandom_range(0, 255));
			else if (kind == 3)
				col[k] = aup_pkg::byte_t'($urandom_range(alpha, 255));
			else
				col[k] = aup_pkg::byte_t'($urandom_range(0, alpha));
		end
		if (order == aup_pkg::ORDER_ARGB)
			return {col[2], col[1], col[0], alpha};
		else
			return {alpha, col[2], col[1], col[0]};
	endfunction

	task automatic report_fault(input string what);
		fault_count++;
		if (fault_count <= REPORT_MAX)
			$display("%0t ns: %s", $realtime, what);
	endtask

	// present one pixel after a random gap and hold it until taken
	task automatic send_pixel(input logic [31:0] px, input logic typed, input result_t want);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		do
			@(posedge clk);
		while (!s_axis_tready);
		pending_pixels.push_back(typed ? want : unpremultiply(channel_order, px));
	endtask

	task automatic drain_pipeline();
		s_axis_tvalid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_order(input logic order);
		drain_pipeline();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= order;
		@(posedge clk);
		cfg_wr_en     <= 1'b0;
		channel_order = order;
	endtask

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	always @(posedge clk) begin : check_output
		result_t want;
		bit      bad;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_pixels.size() == 0) begin
				report_fault($sformatf("unexpected word %h sat %b", m_axis_tdata, m_axis_tuser));
			end else begin
				want = pending_pixels.pop_front();
				bad  = (want.sat != m_axis_tuser);
				for (int i = 0; i < aup_pkg::NUM_BYTES; i++)
					if (want.px[i*aup_pkg::BYTE_W +: aup_pkg::BYTE_W] !=
					    m_axis_tdata[i*aup_pkg::BYTE_W +: aup_pkg::BYTE_W])
						bad = 1'b1;
				if (bad)
					report_fault($sformatf("expected %h sat %b, got %h sat %b",
						want.px, want.sat, m_axis_tdata, m_axis_tuser));
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int r = 0; r < NUM_ROWS; r++) begin
			if (DIRECTED[r].order != channel_order)
				write_order(DIRECTED[r].order);
			send_pixel(DIRECTED[r].px, DIRECTED[r].typed,
				'{px: DIRECTED[r].want_px, sat: DIRECTED[r].want_sat});
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_order(PHASES[p].order);
			src_idle_pct   = PHASES[p].src_idle;
			sink_stall_pct = PHASES[p].sink_stall;
			for (int n = 0; n < PHASE_PIXELS; n++)
				send_pixel(random_pixel(channel_order), 1'b0, '0);
		end

		drain_pipeline();
		if (pending_pixels.size() != 0)
			report_fault($sformatf("%0d results never arrived", pending_pixels.size()));
		if (fault_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
